// File: rtl/dbcd_pkg.sv
// Package for the dictionary bitmask code decompressor.
// Holds the operation codes, fixed widths and the load record for the output stage.
// No dependencies.
package dbcd_pkg;

	localparam int WORD_BITS = 32;
	localparam int OP_BITS   = 3;
	localparam int IDX_BITS  = 3;
	localparam int CNT_BITS  = 2;
	localparam int REG_COUNT = 8;
	localparam int REG_BITS  = 3;
	localparam int IN_BYTES  = (OP_BITS + WORD_BITS + 7) / 8;

	// Compressed code options.
	typedef enum logic [OP_BITS-1:0] {
		OP_REPEAT  = 3'b000,
		OP_BITMASK = 3'b001,
		OP_ONE_BIT = 3'b010,
		OP_TWO_ADJ = 3'b011,
		OP_TWO_ANY = 3'b100,
		OP_DIRECT  = 3'b101,
		OP_RAW     = 3'b110,
		OP_PAD     = 3'b111
	} op_t;

	// What the input stage hands to the output stage when it advances.
	typedef struct packed {
		logic                 load;
		logic                 repeat_run;
		logic [CNT_BITS-1:0]  count;
		logic [WORD_BITS-1:0] word;
	} load_t;

endpackage

// File: rtl/dictionary_bitmask_code_decompressor.sv
// Top level of the dictionary bitmask code decompressor.
// Two register stages: a code is taken into the input register, then loaded into the
// output register, whose word the master side sees; the output can stall the load.
// One code per cycle while the output register is free to load; a run code repeats its
// word count+1 times, set by the repeat counter in the output register.
// Padding codes are dropped in the input register and give no word.
// Reset is asynchronous, active low: dictionary and last word clear to zero.
module dictionary_bitmask_code_decompressor import dbcd_pkg::*; #(
	parameter int DICT_ENTRIES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [REG_BITS-1:0]    wr_index,
	input  logic [WORD_BITS-1:0]   wr_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_BYTES*8-1:0]  s_axis_tdata,  // operation[2:0], payload[34:3], zero fill
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [WORD_BITS-1:0]   m_axis_tdata,  // word[31:0]
	output logic                   m_axis_tlast
);

	logic [DICT_ENTRIES-1:0][WORD_BITS-1:0] dict;
	logic                 valid_s1;
	op_t                  op_s1;
	logic [WORD_BITS-1:0] payload_s1;
	logic                 advance;
	logic                 out_free;
	load_t                ld;

	dbcd_dict #(.DICT_ENTRIES(DICT_ENTRIES)) u_dict (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.dict     (dict)
	);

	// A padding code leaves at once; any other waits for room at the output.
	assign advance       = valid_s1 && ((op_s1 == OP_PAD) || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1      <= op_t'(s_axis_tdata[OP_BITS-1:0]);
			payload_s1 <= s_axis_tdata[OP_BITS+WORD_BITS-1:OP_BITS];
		end
	end

	dbcd_rebuild #(.DICT_ENTRIES(DICT_ENTRIES)) u_rebuild (
		.dict      (dict),
		.valid     (advance),
		.operation (op_s1),
		.payload   (payload_s1),
		.ld        (ld)
	);

	dbcd_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.ld            (ld),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.free          (out_free)
	);

endmodule

// File: rtl/dbcd_dict.sv
// Dictionary register file written through the configuration port.
// Depends on dbcd_pkg for widths.
module dbcd_dict import dbcd_pkg::*; #(
	parameter int DICT_ENTRIES = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic [REG_BITS-1:0]                     wr_index,
	input  logic [WORD_BITS-1:0]                    wr_data,
	output logic [DICT_ENTRIES-1:0][WORD_BITS-1:0]  dict
);

	logic [DICT_ENTRIES-1:0][WORD_BITS-1:0] dict_q;

	// Writes beyond the dictionary depth are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_q <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < DICT_ENTRIES; i++) begin
				if (wr_index == REG_BITS'(i)) begin
					dict_q[i] <= wr_data;
				end
			end
		end
	end

	assign dict = dict_q;

endmodule

// File: rtl/dbcd_rebuild.sv
// Word reconstruction for one code: dictionary lookup and bit flips.
// Depends on dbcd_pkg for operation codes and the load record.
module dbcd_rebuild import dbcd_pkg::*; #(
	parameter int DICT_ENTRIES = 8
) (
	input  logic [DICT_ENTRIES-1:0][WORD_BITS-1:0] dict,
	input  logic                                   valid,
	input  op_t                                    operation,
	input  logic [WORD_BITS-1:0]                   payload,
	output load_t                                  ld
);

	localparam int DIDX_BITS = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;

	logic [IDX_BITS-1:0]  idx;
	logic [WORD_BITS-1:0] entry;
	logic [4:0]           pos_a;
	logic [4:0]           pos_b;
	logic [3:0]           mask;
	logic [WORD_BITS-1:0] flip;

	assign idx   = payload[2:0];
	assign pos_b = payload[7:3];
	assign mask  = payload[6:3];

	// Indexes past the dictionary depth read as zero.
	always_comb begin
		if ({29'd0, idx} < DICT_ENTRIES) begin
			entry = dict[idx[DIDX_BITS-1:0]];
		end else begin
			entry = '0;
		end
	end

	// Position fields sit at different offsets depending on the option.
	always_comb begin
		pos_a = payload[7:3];
		flip  = '0;
		case (operation)
			OP_BITMASK: begin
				pos_a = payload[11:7];
				flip  = {mask, 28'd0} >> pos_a;
			end
			OP_ONE_BIT: begin
				flip = 32'h8000_0000 >> pos_b;
			end
			OP_TWO_ADJ: begin
				// The second bit falls off the end at position 31.
				flip = 32'hC000_0000 >> pos_b;
			end
			OP_TWO_ANY: begin
				pos_a = payload[12:8];
				flip  = (32'h8000_0000 >> pos_a) ^ (32'h8000_0000 >> pos_b);
			end
			default: begin
				flip = '0;
			end
		endcase
	end

	// Assemble the load record; padding never loads the output stage.
	always_comb begin
		ld.load       = valid && (operation != OP_PAD);
		ld.repeat_run = (operation == OP_REPEAT);
		ld.count      = (operation == OP_REPEAT) ? payload[1:0] : '0;
		case (operation)
			OP_RAW:  ld.word = payload;
			default: ld.word = entry ^ flip;
		endcase
	end

endmodule

// File: rtl/dbcd_out.sv
// Output register with repeat counter and the last-word history.
// Depends on dbcd_pkg for the load record.
module dbcd_out import dbcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  load_t                ld,
	input  logic                 m_axis_tready,
	output logic                 m_axis_tvalid,
	output logic [WORD_BITS-1:0] m_axis_tdata,  // word
	output logic                 m_axis_tlast,
	output logic                 free
);

	logic                 valid_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] prev_q;
	logic                 take;

	assign take = valid_q && m_axis_tready;
	// The register can take a new code once its final word leaves.
	assign free = !valid_q || (take && (cnt_q == '0));

	// Control state: valid flag, remaining repeat copies and the last-word history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
			prev_q  <= '0;
		end else if (free && ld.load) begin
			valid_q <= 1'b1;
			cnt_q   <= ld.count;
			if (!ld.repeat_run) begin
				prev_q <= ld.word;
			end
		end else if (take) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Word payload: a run repeats the word given last.
	always_ff @(posedge clk) begin
		if (free && ld.load) begin
			word_q <= ld.repeat_run ? prev_q : ld.word;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = word_q;
	assign m_axis_tlast  = (cnt_q == '0);

	// A held word always matches the history register.
	a_prev_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (word_q == prev_q))
		else $error("output word differs from last-word history");

	// A non-final copy of a run is followed by another copy of the same word.
	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (cnt_q != '0)) |=> (valid_q && $stable(word_q)))
		else $error("repeat run broken before its last copy");

	// The counter only moves down on a handshake or reloads on a new code.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !m_axis_tready) |=> $stable(cnt_q))
		else $error("repeat count changed while stalled");

endmodule
